/* hdl/gssv_pkg.sv */
// Shared opcodes, constants and item types of the grid step sequencer.
package gssv_pkg;

  localparam logic [2:0] OP_PRESS   = 3'd0;
  localparam logic [2:0] OP_RELEASE = 3'd1;
  localparam logic [2:0] OP_HOLD    = 3'd2;
  localparam logic [2:0] OP_CLOCK   = 3'd3;
  localparam logic [2:0] OP_WSTEP   = 3'd4;
  localparam logic [2:0] OP_WLEN    = 3'd5;

  // Voices reported per clock half
  localparam int MAX_REPORT = 4;

  typedef struct packed {
    logic [3:0] dur;
    logic       gate;
    logic [2:0] y;
    logic [2:0] x;
  } gssv_entry_t;

  typedef struct packed {
    logic [2:0]  op;
    logic [1:0]  voice;
    logic        ok;
    logic [5:0]  button;
    logic        hold;
    logic [3:0]  idx;
    gssv_entry_t entry;
    logic [4:0]  len;
  } gssv_cmd_t;

  typedef struct packed {
    logic [1:0] voice;
    logic [5:0] note;
    logic       gate;
    logic       led;
    logic       clk_lvl;
    logic       last;
  } gssv_res_t;

endpackage

/* hdl/gssv_front.sv */
// Front end: accepts items, drops those without effect, normalizes and queues commands.
module gssv_front #(
  parameter int VOICES = 4,
  parameter int STEPS  = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  output logic              full,
  input  logic              stall,
  input  logic [2:0]        in_opcode,
  input  logic [1:0]        in_voice,
  input  logic [5:0]        in_button,
  input  logic              in_hold_value,
  input  logic [3:0]        in_step_index,
  input  logic [2:0]        in_step_offset_x,
  input  logic [2:0]        in_step_offset_y,
  input  logic              in_step_gate_on,
  input  logic [3:0]        in_step_duration,
  input  logic [4:0]        in_seq_length,
  output logic              cmd_valid,
  output gssv_pkg::gssv_cmd_t cmd,
  input  logic              cmd_pop
);
  import gssv_pkg::*;

  gssv_cmd_t  q_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  gssv_cmd_t  cls;
  logic       keep, enq, deq;

  always_comb begin
    cls.op     = in_opcode;
    cls.voice  = in_voice;
    cls.ok     = 32'(in_voice) < VOICES;
    cls.button = in_button;
    cls.hold   = in_hold_value;
    cls.idx    = in_step_index;
    cls.entry.x    = in_step_offset_x;
    cls.entry.y    = in_step_offset_y;
    cls.entry.gate = in_step_gate_on;
    cls.entry.dur  = (in_step_duration == 4'd0) ? 4'd1 : in_step_duration;
    if (in_seq_length == 5'd0) begin
      cls.len = 5'd1;
    end else if (32'(in_seq_length) > STEPS) begin
      cls.len = 5'(STEPS);
    end else begin
      cls.len = in_seq_length;
    end
    case (in_opcode)
      OP_PRESS, OP_RELEASE, OP_HOLD, OP_CLOCK: keep = 1'b1;
      OP_WSTEP: keep = cls.ok && (32'(in_step_index) < STEPS);
      OP_WLEN:  keep = cls.ok;
      default:  keep = 1'b0;
    endcase
  end

  assign full      = (cnt_r == 2'd2) || stall;
  assign enq       = push && !full && keep;
  assign cmd_valid = (cnt_r != 2'd0);
  assign deq       = cmd_pop && cmd_valid;
  assign cmd       = q_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (enq) begin
        wp_r <= ~wp_r;
      end
      if (deq) begin
        rp_r <= ~rp_r;
      end
      cnt_r <= cnt_r + 2'(enq) - 2'(deq);
    end
  end

  always_ff @(posedge clk) begin
    if (enq) begin
      q_r[wp_r] <= cls;
    end
  end

endmodule

/* hdl/gssv_back.sv */
// Back end: voice state, step memory and the sequencer that executes commands.
module gssv_back #(
  parameter int VOICES = 4,
  parameter int STEPS  = 16,
  parameter int GRID_W = 8,
  parameter int GRID_H = 8
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cmd_valid,
  input  gssv_pkg::gssv_cmd_t cmd,
  output logic                cmd_pop,
  input  logic                res_full,
  output logic                res_push,
  output gssv_pkg::gssv_res_t res,
  output logic                clearing
);
  import gssv_pkg::*;

  localparam int VIW   = (VOICES > 1) ? $clog2(VOICES) : 1;
  localparam int SW    = $clog2(STEPS);
  localparam int LMAX  = (STEPS > 4) ? STEPS : 4;
  localparam int LW    = $clog2(LMAX + 1);
  localparam int PSW   = $clog2(LMAX);
  localparam int DEPTH = VOICES * STEPS;
  localparam int AW    = $clog2(DEPTH);
  localparam int NREP  = (VOICES < MAX_REPORT) ? VOICES : MAX_REPORT;
  localparam int BTN_N  = 64;
  localparam int SUMX_N = 23;  // column 0..15 plus offset 0..7
  localparam int SUMY_N = 39;  // row 0..31 plus offset 0..7

  localparam logic [2:0] S_CLR   = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_EXEC  = 3'd2;
  localparam logic [2:0] S_MOD   = 3'd3;
  localparam logic [2:0] S_RD    = 3'd4;
  localparam logic [2:0] S_APPLY = 3'd5;
  localparam logic [2:0] S_EMIT  = 3'd6;

  // per-voice state
  logic          playing_r [VOICES];
  logic          held_r    [VOICES];
  logic          hold_r    [VOICES];
  logic [5:0]    start_r   [VOICES];
  logic [PSW-1:0] pos_r    [VOICES];
  logic [5:0]    now_r     [VOICES];
  logic          gate_r    [VOICES];
  logic [4:0]    ticks_r   [VOICES];
  logic [LW-1:0] len_r     [VOICES];

  gssv_entry_t   mem_r [DEPTH];
  gssv_entry_t   rdata_r;

  logic [2:0]     st_r;
  gssv_cmd_t      cmd_r;
  logic [VIW-1:0] i_r;
  logic           phase_r;
  logic [LW-1:0]  p_r;
  logic [VIW-1:0] clr_v_r;
  logic [SW-1:0]  clr_s_r;

  logic [VIW-1:0] sel;
  logic           is_clk, do_load, rep, valid;
  logic [4:0]     ticks_dec;
  logic           mem_we, mem_re;
  logic [AW-1:0]  mem_wa, mem_ra;
  gssv_entry_t    mem_wd;

  // constant division tables for the grid wrap
  logic [3:0] col_tab  [BTN_N];
  logic [4:0] row_tab  [BTN_N];
  logic [3:0] modx_tab [SUMX_N];
  logic [3:0] mody_tab [SUMY_N];
  logic [5:0] st_btn;
  logic [4:0] sum_x;
  logic [5:0] sum_y;
  logic [3:0] xm, ym;
  logic [7:0] lin;
  logic [5:0] new_btn;

  for (genvar b = 0; b < BTN_N; b++) begin : g_btn
    assign col_tab[b] = 4'(b % GRID_W);
    assign row_tab[b] = 5'(b / GRID_W);
  end
  for (genvar s = 0; s < SUMX_N; s++) begin : g_mx
    assign modx_tab[s] = 4'(s % GRID_W);
  end
  for (genvar s = 0; s < SUMY_N; s++) begin : g_my
    assign mody_tab[s] = 4'(s % GRID_H);
  end

  assign is_clk  = (cmd_r.op == OP_CLOCK);
  assign sel     = is_clk ? i_r : VIW'(cmd_r.voice);
  assign do_load = cmd_r.ok && !held_r[sel] &&
                   !(playing_r[sel] && (start_r[sel] == cmd_r.button));
  assign rep     = !is_clk || (32'(i_r) < NREP);
  assign valid   = is_clk || cmd_r.ok;
  assign ticks_dec = ticks_r[sel] - 5'd1;

  assign st_btn  = start_r[sel];
  assign sum_x   = 5'(col_tab[st_btn]) + 5'(rdata_r.x);
  assign sum_y   = 6'(row_tab[st_btn]) + 6'(rdata_r.y);
  assign xm      = modx_tab[sum_x];
  assign ym      = mody_tab[sum_y];
  assign lin     = 8'(ym) * 8'(GRID_W) + 8'(xm);
  assign new_btn = lin[5:0];

  assign clearing = (st_r == S_CLR);
  assign cmd_pop  = (st_r == S_IDLE) && cmd_valid;
  assign res_push = (st_r == S_EMIT) && rep && !res_full;

  always_comb begin
    res.voice   = is_clk ? 2'(i_r) : cmd_r.voice;
    res.note    = valid ? now_r[sel] : 6'd0;
    res.gate    = valid ? gate_r[sel] : 1'b0;
    res.led     = valid ? playing_r[sel] : 1'b0;
    res.clk_lvl = phase_r;
    res.last    = !is_clk || (32'(i_r) == NREP - 1);
  end

  always_comb begin
    mem_we = 1'b0;
    mem_wa = AW'(32'(cmd_r.voice) * STEPS + 32'(cmd_r.idx));
    mem_wd = cmd_r.entry;
    mem_re = 1'b0;
    mem_ra = AW'(32'(sel) * STEPS + 32'(p_r));
    case (st_r)
      S_CLR: begin
        mem_we      = 1'b1;
        mem_wa      = AW'(32'(clr_v_r) * STEPS + 32'(clr_s_r));
        mem_wd.x    = 3'(clr_s_r);
        mem_wd.y    = 3'(clr_s_r);
        mem_wd.gate = 1'b1;
        mem_wd.dur  = 4'd1;
      end
      S_EXEC: begin
        if (cmd_r.op == OP_WSTEP) begin
          mem_we = 1'b1;
        end
        if (cmd_r.op == OP_PRESS && do_load) begin
          mem_re = 1'b1;
          mem_ra = AW'(32'(sel) * STEPS);
        end
      end
      S_MOD: begin
        mem_re = (p_r < len_r[sel]);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem_r[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      rdata_r <= mem_r[mem_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r    <= S_CLR;
      clr_v_r <= '0;
      clr_s_r <= '0;
      i_r     <= '0;
      phase_r <= 1'b0;
      for (int v = 0; v < VOICES; v++) begin
        playing_r[v] <= 1'b0;
        held_r[v]    <= 1'b0;
        hold_r[v]    <= 1'b0;
        start_r[v]   <= 6'd0;
        pos_r[v]     <= '0;
        now_r[v]     <= 6'd0;
        gate_r[v]    <= 1'b0;
        ticks_r[v]   <= 5'd0;
        len_r[v]     <= LW'(4);
      end
    end else begin
      case (st_r)
        S_CLR: begin
          if (clr_s_r == SW'(STEPS - 1)) begin
            clr_s_r <= '0;
            if (clr_v_r == VIW'(VOICES - 1)) begin
              st_r <= S_IDLE;
            end else begin
              clr_v_r <= clr_v_r + VIW'(1);
            end
          end else begin
            clr_s_r <= clr_s_r + SW'(1);
          end
        end
        S_IDLE: begin
          if (cmd_valid) begin
            cmd_r <= cmd;
            i_r   <= '0;
            if (cmd.op == OP_CLOCK) begin
              phase_r <= ~phase_r;
            end
            st_r <= S_EXEC;
          end
        end
        S_EXEC: begin
          st_r <= S_EMIT;
          case (cmd_r.op)
            OP_PRESS: begin
              if (cmd_r.ok && !held_r[sel]) begin
                held_r[sel] <= 1'b1;
              end
              if (do_load) begin
                st_r <= S_RD;
              end
            end
            OP_RELEASE: begin
              if (cmd_r.ok && held_r[sel] && cmd_r.button == start_r[sel]) begin
                held_r[sel] <= 1'b0;
                if (!hold_r[sel]) begin
                  playing_r[sel] <= 1'b0;
                  gate_r[sel]    <= 1'b0;
                end
              end
            end
            OP_HOLD: begin
              if (cmd_r.ok) begin
                hold_r[sel] <= cmd_r.hold;
                if (!cmd_r.hold && playing_r[sel] && !held_r[sel]) begin
                  playing_r[sel] <= 1'b0;
                  gate_r[sel]    <= 1'b0;
                end
              end
            end
            OP_CLOCK: begin
              if (phase_r) begin
                if (playing_r[sel]) begin
                  if (ticks_dec != 5'd0) begin
                    ticks_r[sel] <= ticks_dec;
                  end else begin
                    p_r  <= LW'(pos_r[sel]) + LW'(1);
                    st_r <= S_MOD;
                  end
                end
              end else if (playing_r[sel] && ticks_r[sel] <= 5'd1) begin
                gate_r[sel] <= 1'b0;
              end
            end
            OP_WSTEP: st_r <= S_IDLE;
            OP_WLEN: begin
              len_r[sel] <= LW'(cmd_r.len);
              st_r       <= S_IDLE;
            end
            default: st_r <= S_IDLE;
          endcase
        end
        S_MOD: begin
          // wrap the next step by repeated subtraction of the length
          if (p_r >= len_r[sel]) begin
            p_r <= p_r - len_r[sel];
          end else begin
            st_r <= S_RD;
          end
        end
        S_RD: st_r <= S_APPLY;
        S_APPLY: begin
          gate_r[sel] <= rdata_r.gate;
          if (cmd_r.op == OP_PRESS) begin
            playing_r[sel] <= 1'b1;
            start_r[sel]   <= cmd_r.button;
            pos_r[sel]     <= '0;
            now_r[sel]     <= cmd_r.button;
            ticks_r[sel]   <= 5'(rdata_r.dur) + 5'(!phase_r);
          end else begin
            pos_r[sel]   <= PSW'(p_r);
            now_r[sel]   <= new_btn;
            ticks_r[sel] <= 5'(rdata_r.dur);
          end
          st_r <= S_EMIT;
        end
        S_EMIT: begin
          if (!rep || !res_full) begin
            if (is_clk && i_r != VIW'(VOICES - 1)) begin
              i_r  <= i_r + VIW'(1);
              st_r <= S_EXEC;
            end else begin
              st_r <= S_IDLE;
            end
          end
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

endmodule

/* hdl/gssv_outq.sv */
// Result queue: four-entry buffer between the sequencer and the result port.
module gssv_outq (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                wr,
  input  gssv_pkg::gssv_res_t din,
  output logic                wfull,
  input  logic                rd,
  output gssv_pkg::gssv_res_t dout,
  output logic                rempty
);
  import gssv_pkg::*;

  gssv_res_t  q_r [4];
  logic [1:0] wp_r, rp_r;
  logic [2:0] cnt_r;
  logic       enq, deq;

  assign wfull  = (cnt_r == 3'd4);
  assign rempty = (cnt_r == 3'd0);
  assign enq    = wr && !wfull;
  assign deq    = rd && !rempty;
  assign dout   = q_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 2'd0;
      rp_r  <= 2'd0;
      cnt_r <= 3'd0;
    end else begin
      if (enq) begin
        wp_r <= wp_r + 2'd1;
      end
      if (deq) begin
        rp_r <= rp_r + 2'd1;
      end
      cnt_r <= cnt_r + 3'(enq) - 3'(deq);
    end
  end

  always_ff @(posedge clk) begin
    if (enq) begin
      q_r[wp_r] <= din;
    end
  end

endmodule

/* hdl/grid_step_sequencer_voices_top.sv */
// Top level of the grid step sequencer: front queue, sequencer and result queue.
// Four-voice step sequencer for a button grid. Items enter through a two-deep
// command queue; one sequencer works them one at a time, visiting voices in
// turn over a single step-memory port. A press that starts a voice reads its
// first step; a clock half visits every voice, and a voice that moves to its
// next step wraps its position by subtracting the length, then reads the step.
// Results leave through a four-entry queue so the sequencer keeps going while
// results wait. After reset the step memory is swept to its defaults, during
// which full stays high.
module grid_step_sequencer_voices_top #(
  parameter int VOICES = 4,
  parameter int STEPS  = 16,
  parameter int GRID_W = 8,
  parameter int GRID_H = 8
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  output logic       full,
  input  logic [2:0] in_opcode,
  input  logic [1:0] in_voice,
  input  logic [5:0] in_button,
  input  logic       in_hold_value,
  input  logic [3:0] in_step_index,
  input  logic [2:0] in_step_offset_x,
  input  logic [2:0] in_step_offset_y,
  input  logic       in_step_gate_on,
  input  logic [3:0] in_step_duration,
  input  logic [4:0] in_seq_length,
  output logic       empty,
  input  logic       pop,
  output logic [1:0] out_voice,
  output logic [5:0] out_note_button,
  output logic       out_gate_out,
  output logic       out_led_on,
  output logic       out_clock_out,
  output logic       out_last
);
  import gssv_pkg::*;

  logic      cmd_valid, cmd_pop, clearing, res_push, res_full;
  gssv_cmd_t cmd;
  gssv_res_t res, res_q;

  gssv_front #(.VOICES(VOICES), .STEPS(STEPS)) u_front (
    .clk, .rst_n, .push, .full, .stall(clearing),
    .in_opcode, .in_voice, .in_button, .in_hold_value, .in_step_index,
    .in_step_offset_x, .in_step_offset_y, .in_step_gate_on,
    .in_step_duration, .in_seq_length,
    .cmd_valid, .cmd, .cmd_pop
  );

  gssv_back #(.VOICES(VOICES), .STEPS(STEPS), .GRID_W(GRID_W), .GRID_H(GRID_H)) u_back (
    .clk, .rst_n, .cmd_valid, .cmd, .cmd_pop,
    .res_full, .res_push, .res, .clearing
  );

  gssv_outq u_outq (
    .clk, .rst_n, .wr(res_push), .din(res), .wfull(res_full),
    .rd(pop), .dout(res_q), .rempty(empty)
  );

  assign out_voice       = res_q.voice;
  assign out_note_button = res_q.note;
  assign out_gate_out    = res_q.gate;
  assign out_led_on      = res_q.led;
  assign out_clock_out   = res_q.clk_lvl;
  assign out_last        = res_q.last;

endmodule

/* hdl/gssv_checker.sv */
// Port-level checks of the grid step sequencer, bound to the top level.
module gssv_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       push,
  input logic       full,
  input logic       pop,
  input logic       empty,
  input logic [1:0] out_voice,
  input logic [5:0] out_note_button,
  input logic       out_gate_out,
  input logic       out_led_on,
  input logic       out_clock_out,
  input logic       out_last
);

  // memory sweep keeps input closed right after reset
  a_full_after_rst: assert property (@(posedge clk) !rst_n |=> full)
    else $error("full low right after reset");

  a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !empty && !pop |=> !empty && $stable(out_voice) && $stable(out_note_button) &&
      $stable(out_gate_out) && $stable(out_led_on) && $stable(out_clock_out) &&
      $stable(out_last))
    else $error("waiting item changed");

  // a stopped voice never has its gate up
  a_gate_needs_led: assert property (@(posedge clk) disable iff (!rst_n)
    !empty |-> (out_led_on || !out_gate_out))
    else $error("gate high on idle voice");

  // a report from voice three is always marked last
  a_nonlast_voice: assert property (@(posedge clk) disable iff (!rst_n)
    !empty && !out_last |-> out_voice != 2'd3)
    else $error("voice three not marked last");

endmodule

bind grid_step_sequencer_voices_top gssv_checker u_gssv_checker (.*);

/* sim/grid_step_sequencer_voices_top_tb.sv */
// Testbench for the grid step sequencer: directed and random commands, checked per voice report.
module grid_step_sequencer_voices_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import gssv_pkg::*;

  localparam int N_VOICES        = 4;
  localparam int N_STEPS         = 16;
  localparam int GRID_COLS       = 8;
  localparam int GRID_ROWS       = 8;
  localparam int RANDOM_CMDS     = 85;
  localparam int DRAIN_CYCLES    = 150;
  localparam int WATCHDOG_CYCLES = 3000;

  // Opcodes the block decodes as no-ops
  localparam logic [2:0] OP_SPARE_6 = 3'd6;
  localparam logic [2:0] OP_SPARE_7 = 3'd7;

  typedef struct {
    logic [2:0] op;
    logic [1:0] voice;
    logic [5:0] button;
    logic       hold;
    logic [3:0] idx;
    logic [2:0] off_x;
    logic [2:0] off_y;
    logic       gate_on;
    logic [3:0] dur;
    logic [4:0] len;
  } grid_cmd_t;

  logic       clk = 1'b0;
  logic       rst_n;
  logic       push;
  logic       full;
  logic [2:0] in_opcode;
  logic [1:0] in_voice;
  logic [5:0] in_button;
  logic       in_hold_value;
  logic [3:0] in_step_index;
  logic [2:0] in_step_offset_x;
  logic [2:0] in_step_offset_y;
  logic       in_step_gate_on;
  logic [3:0] in_step_duration;
  logic [4:0] in_seq_length;
  logic       empty;
  logic       pop;
  logic [1:0] out_voice;
  logic [5:0] out_note_button;
  logic       out_gate_out;
  logic       out_led_on;
  logic       out_clock_out;
  logic       out_last;

  grid_step_sequencer_voices_top #(
    .VOICES(N_VOICES),
    .STEPS (N_STEPS),
    .GRID_W(GRID_COLS),
    .GRID_H(GRID_ROWS)
  ) dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .push            (push),
    .full            (full),
    .in_opcode       (in_opcode),
    .in_voice        (in_voice),
    .in_button       (in_button),
    .in_hold_value   (in_hold_value),
    .in_step_index   (in_step_index),
    .in_step_offset_x(in_step_offset_x),
    .in_step_offset_y(in_step_offset_y),
    .in_step_gate_on (in_step_gate_on),
    .in_step_duration(in_step_duration),
    .in_seq_length   (in_seq_length),
    .empty           (empty),
    .pop             (pop),
    .out_voice       (out_voice),
    .out_note_button (out_note_button),
    .out_gate_out    (out_gate_out),
    .out_led_on      (out_led_on),
    .out_clock_out   (out_clock_out),
    .out_last        (out_last)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Sequencer state as the testbench sees it
  logic        clock_level;
  logic        playing    [N_VOICES];
  logic        held_down  [N_VOICES];
  logic        hold_mode  [N_VOICES];
  logic [5:0]  start_btn  [N_VOICES];
  logic [3:0]  step_pos   [N_VOICES];
  logic [5:0]  now_btn    [N_VOICES];
  logic        gate_lvl   [N_VOICES];
  logic [4:0]  ticks_left [N_VOICES];
  logic [4:0]  seq_len    [N_VOICES];
  gssv_entry_t step_table [N_VOICES][N_STEPS];

  gssv_res_t pending_reports[$];
  gssv_res_t want_report;

  int fail_count      = 0;
  int reports_checked = 0;
  int cmds_sent       = 0;
  int step_advances   = 0;
  int burst_left      = 0;
  int idle_cycles     = 0;
  int stall_mode      = 0;
  int stall_run       = 0;
  int rx_cycle        = 0;

  function automatic void reset_sequencer_state();
    clock_level = 1'b0;
    for (int v = 0; v < N_VOICES; v++) begin
      playing[v]    = 1'b0;
      held_down[v]  = 1'b0;
      hold_mode[v]  = 1'b0;
      start_btn[v]  = '0;
      step_pos[v]   = '0;
      now_btn[v]    = '0;
      gate_lvl[v]   = 1'b0;
      ticks_left[v] = '0;
      seq_len[v]    = 5'd4;
      for (int s = 0; s < N_STEPS; s++)
        step_table[v][s] = '{dur: 4'd1, gate: 1'b1, y: s[2:0], x: s[2:0]};
    end
  endfunction

  function automatic void report_voice(int v, logic is_last);
    pending_reports.push_back('{voice: v[1:0], note: now_btn[v], gate: gate_lvl[v],
                                led: playing[v], clk_lvl: clock_level, last: is_last});
  endfunction

  function automatic void stop_voice(int v);
    playing[v]  = 1'b0;
    gate_lvl[v] = 1'b0;
  endfunction

  // Rising half: count down the gate, move to the next step when it runs out
  function automatic void count_down_voice(int v);
    gssv_entry_t e;
    int          next_pos;
    int          col;
    int          row;
    if (!playing[v])
      return;
    ticks_left[v] = ticks_left[v] - 5'd1;
    if (ticks_left[v] != 0)
      return;
    next_pos = (int'(step_pos[v]) + 1) % int'(seq_len[v]);
    step_pos[v] = next_pos[3:0];
    e   = step_table[v][next_pos];
    col = (int'(start_btn[v]) % GRID_COLS + int'(e.x)) % GRID_COLS;
    row = (int'(start_btn[v]) / GRID_COLS + int'(e.y)) % GRID_ROWS;
    now_btn[v]    = 6'(row * GRID_COLS + col);
    gate_lvl[v]   = e.gate;
    ticks_left[v] = {1'b0, e.dur};
    step_advances++;
  endfunction

  function automatic void predict_cmd(grid_cmd_t c);
    gssv_entry_t e;
    int          v;
    int          n_rep;
    v = int'(c.voice);
    case (c.op)
      OP_PRESS: begin
        if (!held_down[v]) begin
          held_down[v] = 1'b1;
          if (!(playing[v] && start_btn[v] == c.button)) begin
            e = step_table[v][0];
            playing[v]    = 1'b1;
            start_btn[v]  = c.button;
            step_pos[v]   = '0;
            now_btn[v]    = c.button;
            gate_lvl[v]   = e.gate;
            // first gate is a tick longer when pressed in the low half
            ticks_left[v] = 5'(e.dur) + (clock_level ? 5'd0 : 5'd1);
          end
        end
        report_voice(v, 1'b1);
      end
      OP_RELEASE: begin
        if (held_down[v] && c.button == start_btn[v]) begin
          held_down[v] = 1'b0;
          if (!hold_mode[v])
            stop_voice(v);
        end
        report_voice(v, 1'b1);
      end
      OP_HOLD: begin
        hold_mode[v] = c.hold;
        if (!c.hold && playing[v] && !held_down[v])
          stop_voice(v);
        report_voice(v, 1'b1);
      end
      OP_CLOCK: begin
        clock_level = ~clock_level;
        for (int i = 0; i < N_VOICES; i++) begin
          if (clock_level)
            count_down_voice(i);
          else if (playing[i] && ticks_left[i] <= 5'd1)
            gate_lvl[i] = 1'b0;
        end
        n_rep = (N_VOICES < MAX_REPORT) ? N_VOICES : MAX_REPORT;
        for (int i = 0; i < n_rep; i++)
          report_voice(i, i == n_rep - 1);
      end
      OP_WSTEP: begin
        if (c.idx < N_STEPS)
          step_table[v][c.idx] = '{dur: (c.dur == 4'd0) ? 4'd1 : c.dur, gate: c.gate_on,
                                   y: c.off_y, x: c.off_x};
      end
      OP_WLEN: begin
        if (c.len == 5'd0)
          seq_len[v] = 5'd1;
        else if (c.len > N_STEPS)
          seq_len[v] = 5'(N_STEPS);
        else
          seq_len[v] = c.len;
      end
      default: ;
    endcase
  endfunction

  // Every field random; callers override what the opcode uses
  function automatic grid_cmd_t random_cmd(logic [2:0] op);
    grid_cmd_t c;
    c.op      = op;
    c.voice   = 2'($urandom_range(3));
    c.button  = 6'($urandom_range(63));
    c.hold    = 1'($urandom_range(1));
    c.idx     = 4'($urandom_range(15));
    c.off_x   = 3'($urandom_range(7));
    c.off_y   = 3'($urandom_range(7));
    c.gate_on = 1'($urandom_range(1));
    c.dur     = 4'($urandom_range(15));
    c.len     = 5'($urandom_range(31));
    return c;
  endfunction

  task automatic push_cmd(grid_cmd_t c);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 8);
      gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 10);
      if (gap > 0) begin
        @(negedge clk);
        push <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    push             <= 1'b1;
    in_opcode        <= c.op;
    in_voice         <= c.voice;
    in_button        <= c.button;
    in_hold_value    <= c.hold;
    in_step_index    <= c.idx;
    in_step_offset_x <= c.off_x;
    in_step_offset_y <= c.off_y;
    in_step_gate_on  <= c.gate_on;
    in_step_duration <= c.dur;
    in_seq_length    <= c.len;
    do @(posedge clk); while (full);
    predict_cmd(c);
    if (c.op <= OP_WLEN)
      cmds_sent++;
  endtask

  task automatic send_press(int v, int b);
    grid_cmd_t c;
    c = random_cmd(OP_PRESS);
    c.voice  = 2'(v);
    c.button = 6'(b);
    push_cmd(c);
  endtask

  task automatic send_release(int v, int b);
    grid_cmd_t c;
    c = random_cmd(OP_RELEASE);
    c.voice  = 2'(v);
    c.button = 6'(b);
    push_cmd(c);
  endtask

  task automatic send_hold(int v, int h);
    grid_cmd_t c;
    c = random_cmd(OP_HOLD);
    c.voice = 2'(v);
    c.hold  = 1'(h);
    push_cmd(c);
  endtask

  task automatic send_clocks(int n);
    repeat (n) push_cmd(random_cmd(OP_CLOCK));
  endtask

  task automatic send_step(int v, int idx, int x, int y, int g, int d);
    grid_cmd_t c;
    c = random_cmd(OP_WSTEP);
    c.voice   = 2'(v);
    c.idx     = 4'(idx);
    c.off_x   = 3'(x);
    c.off_y   = 3'(y);
    c.gate_on = 1'(g);
    c.dur     = 4'(d);
    push_cmd(c);
  endtask

  task automatic send_length(int v, int len);
    grid_cmd_t c;
    c = random_cmd(OP_WLEN);
    c.voice = 2'(v);
    c.len   = 5'(len);
    push_cmd(c);
  endtask

  // Presses in both clock halves, a press while the button is down
  task automatic test_press_phases();
    send_press(0, 0);
    send_clocks(2);
    send_clocks(1);
    send_press(1, 63);
    send_press(1, 10);
    send_clocks(3);
  endtask

  // Release of a foreign button, hold keeping a voice alive, re-press of the start button
  task automatic test_release_and_hold();
    send_release(1, 5);
    send_release(1, 63);
    send_hold(0, 1);
    send_release(0, 0);
    send_press(0, 0);
    send_release(0, 0);
    send_hold(0, 0);
  endtask

  // Step and length writes at the field limits, zero duration, spare opcodes
  task automatic test_table_writes();
    send_step(0, 0, 7, 7, 0, 0);
    send_step(3, 15, 0, 0, 1, 15);
    send_length(0, 0);
    send_length(1, 16);
    send_length(2, 31);
    push_cmd(random_cmd(OP_SPARE_6));
    push_cmd(random_cmd(OP_SPARE_7));
    send_press(0, 9);
    send_clocks(2);
  endtask

  // Press / play / release sessions on random voices, with some noise mixed in
  task automatic test_random_sessions();
    int first;
    int v;
    int b;
    first = cmds_sent;
    while (cmds_sent - first < RANDOM_CMDS) begin
      v = $urandom_range(3);
      if ($urandom_range(9) == 0) begin
        push_cmd(random_cmd(3'($urandom_range(7))));
      end else begin
        repeat ($urandom_range(2))
          send_step(v, $urandom_range(15), $urandom_range(7), $urandom_range(7),
                    $urandom_range(1), $urandom_range(3));
        if ($urandom_range(3) == 0)
          send_length(v, $urandom_range(1, 6));
        if ($urandom_range(2) == 0)
          send_hold(v, $urandom_range(1));
        b = $urandom_range(63);
        send_press(v, b);
        send_clocks($urandom_range(1, 8));
        if ($urandom_range(3) == 0)
          send_release(v, $urandom_range(63));
        send_release(v, b);
        if ($urandom_range(1))
          send_clocks($urandom_range(1, 4));
        if ($urandom_range(2) == 0)
          send_hold(v, 0);
      end
    end
  endtask

  // Receiver: pop behavior changes after a random run length
  always @(negedge clk) begin
    if (stall_run == 0) begin
      stall_mode = $urandom_range(3);
      stall_run  = $urandom_range(10, 80);
    end
    stall_run--;
    rx_cycle++;
    case (stall_mode)
      0:       pop <= 1'b1;
      1:       pop <= 1'($urandom_range(1));
      2:       pop <= ($urandom_range(4) == 0);
      default: pop <= rx_cycle[2];
    endcase
  end

  function automatic void compare_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t: report %0d field %s expected %0d, got %0d",
               $time, reports_checked, name, want, got);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin
    if (rst_n && pop && !empty) begin
      if (pending_reports.size() == 0) begin
        $display("%0t: unexpected report voice %0d note %0d, expected none",
                 $time, out_voice, out_note_button);
        fail_count++;
      end else begin
        want_report = pending_reports.pop_front();
        compare_field("voice", 32'(want_report.voice), 32'(out_voice));
        compare_field("note_button", 32'(want_report.note), 32'(out_note_button));
        compare_field("gate_out", 32'(want_report.gate), 32'(out_gate_out));
        compare_field("led_on", 32'(want_report.led), 32'(out_led_on));
        compare_field("clock_out", 32'(want_report.clk_lvl), 32'(out_clock_out));
        compare_field("last", 32'(want_report.last), 32'(out_last));
      end
      reports_checked++;
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (push && !full) || (pop && !empty))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_CYCLES) begin
      $display("%0t: no item moved for %0d cycles, %0d reports outstanding",
               $time, idle_cycles, pending_reports.size());
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    rst_n            = 1'b0;
    push             = 1'b0;
    pop              = 1'b0;
    in_opcode        = OP_PRESS;
    in_voice         = '0;
    in_button        = '0;
    in_hold_value    = 1'b0;
    in_step_index    = '0;
    in_step_offset_x = '0;
    in_step_offset_y = '0;
    in_step_gate_on  = 1'b0;
    in_step_duration = '0;
    in_seq_length    = '0;
    reset_sequencer_state();
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_press_phases();
    test_release_and_hold();
    test_table_writes();
    test_random_sessions();

    @(negedge clk);
    push <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    // writes leave no report; give the last one time to finish
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d commands; checked %0d voice reports, %0d step advances seen.",
             cmds_sent, reports_checked, step_advances);
    $display("Covered presses in both clock halves, hold, foreign releases, table writes.");
    if (fail_count == 0 && pending_reports.size() == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule

/* filelist.f */
hdl/gssv_pkg.sv
hdl/gssv_front.sv
hdl/gssv_back.sv
hdl/gssv_outq.sv
hdl/grid_step_sequencer_voices_top.sv
hdl/gssv_checker.sv
sim/grid_step_sequencer_voices_top_tb.sv
